>>> hw/rtl/klt_pkg.sv
`timescale 1ns / 1ps
// klt_pkg: shared types and constants of the keyword lexer tokenizer
// no dependencies; imported by every module of the block

package klt_pkg;

    localparam int POS_BITS    = 16;  // byte position and token start width
    localparam int LEN_BITS    = 16;  // token length width, saturating
    localparam int KW_CHARS    = 5;   // identifier prefix kept for keyword match
    localparam int KW_IDX_BITS = $clog2(KW_CHARS);
    localparam int MAX_TOK     = 3;   // tokens one byte can cause
    localparam int TOK_CNT_BITS = 2;
    localparam int Q_DEPTH     = 4;   // bundles in the front/back queue
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);

    typedef enum logic [4:0] {
        K_EOF        = 5'd0,
        K_IDENT      = 5'd1,
        K_NUMBER     = 5'd2,
        K_PRINT      = 5'd3,
        K_IF         = 5'd4,
        K_ELSE       = 5'd5,
        K_END        = 5'd6,
        K_WHILE      = 5'd7,
        K_GT         = 5'd8,
        K_GE         = 5'd9,
        K_LT         = 5'd10,
        K_LE         = 5'd11,
        K_ASSIGN     = 5'd12,
        K_EQ         = 5'd13,
        K_NE         = 5'd14,
        K_PLUS       = 5'd15,
        K_MINUS      = 5'd16,
        K_STAR       = 5'd17,
        K_SLASH      = 5'd18,
        K_LPAREN     = 5'd19,
        K_RPAREN     = 5'd20,
        K_BANG_ERR   = 5'd21,
        K_UNEXPECTED = 5'd22
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_IDENT = 3'd1,
        M_NUM   = 3'd2,
        M_GT    = 3'd3,
        M_LT    = 3'd4,
        M_EQ    = 3'd5,
        M_BANG  = 3'd6
    } t_mode;

    typedef struct packed {
        t_kind               kind;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
    } t_token;

    // all tokens caused by one source byte, in emission order
    typedef struct packed {
        logic [TOK_CNT_BITS-1:0] count;
        t_token [MAX_TOK-1:0]    tok;
    } t_bundle;

endpackage

>>> hw/rtl/klt_front.sv
`timescale 1ns / 1ps
// klt_front: per-byte scanner state machine, builds the token bundle of each byte
// depends on klt_pkg

module klt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_ch,
    input  logic            i_final_byte,
    input  logic            i_full,
    output logic            o_push,
    output klt_pkg::t_bundle o_bundle
);
    import klt_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";

    typedef logic [KW_CHARS-1:0][7:0] t_prefix;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_kind kw_kind(input t_prefix p, input logic [LEN_BITS-1:0] len);
        t_kind k;
        k = K_IDENT;
        if (len == LEN_BITS'(5) && p[0] == "p" && p[1] == "r" && p[2] == "i"
            && p[3] == "n" && p[4] == "t") begin
            k = K_PRINT;
        end else if (len == LEN_BITS'(2) && p[0] == "i" && p[1] == "f") begin
            k = K_IF;
        end else if (len == LEN_BITS'(4) && p[0] == "e" && p[1] == "l" && p[2] == "s"
                     && p[3] == "e") begin
            k = K_ELSE;
        end else if (len == LEN_BITS'(3) && p[0] == "e" && p[1] == "n" && p[2] == "d") begin
            k = K_END;
        end else if (len == LEN_BITS'(5) && p[0] == "w" && p[1] == "h" && p[2] == "i"
                     && p[3] == "l" && p[4] == "e") begin
            k = K_WHILE;
        end
        return k;
    endfunction

    // kind of the token closed out of a pending mode
    function automatic t_kind close_kind(input t_mode m, input t_prefix p,
                                         input logic [LEN_BITS-1:0] len);
        t_kind k;
        unique case (m)
            M_IDENT: k = kw_kind(p, len);
            M_NUM:   k = K_NUMBER;
            M_GT:    k = K_GT;
            M_LT:    k = K_LT;
            M_EQ:    k = K_ASSIGN;
            M_BANG:  k = K_BANG_ERR;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    t_mode                  r_mode,   n_mode;
    t_prefix                r_prefix, n_prefix;
    logic [LEN_BITS-1:0]    r_len,    n_len;
    logic [POS_BITS-1:0]    r_start,  n_start;
    logic [POS_BITS-1:0]    r_pos,    n_pos;
    logic                   r_halt,   n_halt;

    t_token [MAX_TOK-1:0]    toks;
    logic [TOK_CNT_BITS-1:0] cnt;
    logic                    accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (cnt != '0);
    assign o_bundle.count = cnt;
    assign o_bundle.tok   = toks;

    always_comb begin
        logic  used;
        t_kind k2;
        used     = 1'b0;
        k2       = K_GE;
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_start  = r_start;
        n_pos    = r_pos;
        n_halt   = r_halt;
        toks     = '0;
        cnt      = '0;

        if (!r_halt) begin
            n_pos = r_pos + 1'b1;

            // pending token: complete, extend or close
            if ((r_mode == M_GT || r_mode == M_LT || r_mode == M_EQ || r_mode == M_BANG)
                && i_ch == CH_EQ) begin
                unique case (r_mode)
                    M_GT:    k2 = K_GE;
                    M_LT:    k2 = K_LE;
                    M_EQ:    k2 = K_EQ;
                    default: k2 = K_NE;
                endcase
                toks[cnt] = '{kind: k2, start: r_start, length: LEN_BITS'(2)};
                cnt       = cnt + 1'b1;
                n_mode    = M_IDLE;
                used      = 1'b1;
            end else if ((r_mode == M_IDENT
                          && (is_letter(i_ch) || is_digit(i_ch) || i_ch == CH_UNDER))
                         || (r_mode == M_NUM && is_digit(i_ch))) begin
                if (r_len < LEN_BITS'(KW_CHARS)) begin
                    n_prefix[r_len[KW_IDX_BITS-1:0]] = i_ch;
                end
                if (r_len != '1) begin
                    n_len = r_len + 1'b1;
                end
                used = 1'b1;
            end else if (r_mode != M_IDLE) begin
                toks[cnt] = '{kind: close_kind(r_mode, r_prefix, r_len),
                              start: r_start, length: r_len};
                cnt    = cnt + 1'b1;
                n_halt = (r_mode == M_BANG);
                n_mode = M_IDLE;
            end

            // byte handled from idle
            if (!n_halt && !used) begin
                if (i_ch == CH_NUL || is_space(i_ch)) begin
                    // separator, nothing to do
                end else if (is_letter(i_ch) || is_digit(i_ch)) begin
                    n_mode      = is_letter(i_ch) ? M_IDENT : M_NUM;
                    n_start     = r_pos;
                    n_len       = LEN_BITS'(1);
                    n_prefix    = '0;
                    n_prefix[0] = i_ch;
                end else if (i_ch == CH_GT || i_ch == CH_LT || i_ch == CH_EQ
                             || i_ch == CH_BANG) begin
                    n_mode   = (i_ch == CH_GT) ? M_GT :
                               (i_ch == CH_LT) ? M_LT :
                               (i_ch == CH_EQ) ? M_EQ : M_BANG;
                    n_start  = r_pos;
                    n_len    = LEN_BITS'(1);
                    n_prefix = '0;
                end else begin
                    priority case (i_ch)
                        CH_PLUS:   k2 = K_PLUS;
                        CH_MINUS:  k2 = K_MINUS;
                        CH_STAR:   k2 = K_STAR;
                        CH_SLASH:  k2 = K_SLASH;
                        CH_LPAREN: k2 = K_LPAREN;
                        CH_RPAREN: k2 = K_RPAREN;
                        default:   k2 = K_UNEXPECTED;
                    endcase
                    toks[cnt] = '{kind: k2, start: r_pos, length: LEN_BITS'(1)};
                    cnt       = cnt + 1'b1;
                    n_halt    = (k2 == K_UNEXPECTED);
                end
            end

            // end of source: close what is left, then, unless that halts, eof and back to reset values
            if (!n_halt && (i_ch == CH_NUL || i_final_byte)) begin
                if (n_mode != M_IDLE) begin
                    toks[cnt] = '{kind: close_kind(n_mode, n_prefix, n_len),
                                  start: n_start, length: n_len};
                    cnt    = cnt + 1'b1;
                    n_halt = (n_mode == M_BANG);
                    n_mode = M_IDLE;
                end
                if (!n_halt) begin
                    toks[cnt] = '{kind: K_EOF,
                                  start: (i_ch == CH_NUL) ? r_pos : r_pos + 1'b1,
                                  length: '0};
                    cnt      = cnt + 1'b1;
                    n_mode   = M_IDLE;
                    n_prefix = '0;
                    n_len    = '0;
                    n_start  = '0;
                    n_pos    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_prefix <= '0;
            r_len    <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_halt   <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_halt   <= n_halt;
        end
    end

endmodule

>>> hw/rtl/klt_queue.sv
`timescale 1ns / 1ps
// klt_queue: short fifo of token bundles between scanner and output stage
// depends on klt_pkg

module klt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  klt_pkg::t_bundle i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output klt_pkg::t_bundle o_head
);
    import klt_pkg::*;

    t_bundle               r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (Q_PTR_BITS+1)'(i_push) - (Q_PTR_BITS+1)'(i_pop);
        end
    end

endmodule

>>> hw/rtl/klt_back.sv
`timescale 1ns / 1ps
// klt_back: unpacks queued bundles into one output token word per cycle while the receiver is ready
// depends on klt_pkg

module klt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  klt_pkg::t_bundle i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output klt_pkg::t_token  o_token,
    output logic             o_last
);
    import klt_pkg::*;

    logic [TOK_CNT_BITS-1:0] r_sel, n_sel;
    logic                    r_valid;
    t_token                  r_token;
    logic                    r_last;
    logic                    load, last_tok;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign last_tok = (r_sel == i_head.count - 1'b1);
    assign o_pop    = load && last_tok;
    assign n_sel    = load ? (last_tok ? '0 : r_sel + 1'b1) : r_sel;

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else begin
            r_sel <= n_sel;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= i_head.tok[r_sel];
            r_last  <= last_tok;
        end
    end

endmodule

>>> hw/rtl/keyword_lexer_tokenizer.sv
`timescale 1ns / 1ps
// keyword_lexer_tokenizer: top level of the streaming keyword lexer
// depends on klt_pkg, klt_front, klt_queue, klt_back

// Takes one source byte per cycle and emits tokens as kind, start position and
// length; last_of_run marks the final token caused by one byte. The scanner
// accepts a byte every cycle while its four-entry bundle queue has room; the
// output stage drains one token word per cycle while the receiver is ready, so
// the tokens of one byte (at most three, eof included) leave one after another.
// The queue is written at the accepting edge, and the output register loads from
// the queue head once it is empty or its word is taken. Identifiers matching
// print, if, else, end or while come out as keyword kinds; a lone '!' or an
// unexpected byte emits an error token and the block then drops every byte until
// reset. A zero byte or final_byte closes the source with an eof token and
// restarts the position count at zero.

module keyword_lexer_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import klt_pkg::*;

    // bundle path from scanner to output stage
    logic    push, full, empty, pop;
    t_bundle push_bundle, head_bundle;
    t_token  out_token;

    // front: byte scanner, stalls only when the queue is full
    klt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .i_final_byte (i_final_byte),
        .i_full       (full),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    // queue decouples byte rate from token rate
    klt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (head_bundle)
    );

    // back: one token word per cycle into the output register while the receiver is ready
    klt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_bundle),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_token (out_token),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind   = out_token.kind;
    assign o_token_start  = out_token.start;
    assign o_token_length = out_token.length;

endmodule

>>> hw/rtl/klt_checker.sv
`timescale 1ns / 1ps
// klt_checker: port-level assertions for the keyword lexer tokenizer
// depends on klt_pkg; bound to keyword_lexer_tokenizer

module klt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_ch,
    input logic        i_final_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_token_kind,
    input logic [15:0] o_token_start,
    input logic [15:0] o_token_length,
    input logic        o_last_of_run
);
    import klt_pkg::*;

    // stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind)
            && $stable(o_token_start) && $stable(o_token_length))
        else $error("output word changed while stalled");

    // eof is empty and always ends its run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_EOF |-> o_token_length == '0 && o_last_of_run)
        else $error("eof token malformed");

    // error tokens halt the scanner, so nothing follows them in the run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_BANG_ERR || o_token_kind == K_UNEXPECTED)
            |-> o_last_of_run && o_token_length == 16'd1)
        else $error("error token not last of run");

    // two-character operators
    a_two_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_GE || o_token_kind == K_LE
            || o_token_kind == K_EQ || o_token_kind == K_NE) |-> o_token_length == 16'd2)
        else $error("two-character operator with wrong length");

endmodule

bind keyword_lexer_tokenizer klt_checker u_klt_checker (.*);
